// File: rtl/pdht_pkg.sv
// shared types and constants for the packet duplicate filter
package pdht_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] WINDOW_RESET = 32'd300000;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [63:0] packet_timestamp;
    logic [63:0] src_id;
  } item_t;

  typedef struct packed {
    logic        is_duplicate;
    logic [31:0] digest;
  } result_t;

  typedef struct packed {
    logic [63:0] time_ms;
    logic [63:0] sender;
    logic [31:0] hash;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic launch;
    logic prime;
    logic scan;
    logic finish;
    logic dup;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
  } status_t;

endpackage

// File: rtl/packet_dedup_hash_table.sv
// top level of the packet duplicate filter
// A payload byte transfer without last_byte leaves busy low, so bytes may
// arrive every cycle. The transfer that carries last_byte starts a scan of the entry ring
// through the single registered read port of the entry memory: busy is high while the read
// is primed, then while the entries are compared one per cycle, stopping early at the first
// match. The result is shown on result_o with result_valid_o for exactly one cycle, in the
// cycle busy falls; the receiver cannot stall it. The ring is empty after reset with no
// clearing pass.
module packet_dedup_hash_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pdht_pkg::item_t   item_i,
  output logic              result_valid_o,
  output pdht_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);
  import pdht_pkg::*;

  cmd_t    cmd;
  status_t status;

  pdht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_byte_i (item_i.last_byte),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  pdht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: rtl/pdht_ctrl.sv
// control state machine: byte transfers, table scan sequencing, finish
module pdht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             last_byte_i,
  input  pdht_pkg::status_t status_i,
  output pdht_pkg::cmd_t   cmd_o,
  output logic             busy
);
  import pdht_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.take = 1'b1;
          if (last_byte_i) begin
            cmd_o.launch = 1'b1;
            state_d      = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.scan_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.dup    = status_i.hit;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/pdht_dp.sv
// datapath: fnv-1a hash, entry ring memory, aging and match compare
module pdht_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdht_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  pdht_pkg::cmd_t    cmd_i,
  output pdht_pkg::status_t status_o,
  output logic              result_valid_o,
  output pdht_pkg::result_t result_o
);
  import pdht_pkg::*;

  logic [31:0]              window_q;
  logic [31:0]              run_hash_q;
  logic [31:0]              hash_next;
  logic [31:0]              pkt_hash_q;
  logic [63:0]              pkt_time_q;
  logic [63:0]              pkt_sender_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         ptr_q;
  logic [IDX_W-1:0]         scan_idx_q;
  logic [IDX_W-1:0]         scan_idx_next;
  logic [IDX_W-1:0]         cmp_idx_q;
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rdata_q;
  entry_t                   wr_entry;
  logic                     wr_en;
  logic [63:0]              age;
  logic                     expire;
  logic                     same;
  logic                     cur_valid;
  logic                     result_valid_q;
  result_t                  result_q;

  assign hash_next = item_i.byte_valid
                   ? (run_hash_q ^ {24'd0, item_i.payload_byte}) * FNV_PRIME
                   : run_hash_q;

  assign scan_idx_next = (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + 1'b1;

  assign cur_valid = valid_q[cmp_idx_q];
  assign age       = pkt_time_q - rdata_q.time_ms;
  assign expire    = (pkt_time_q > rdata_q.time_ms) && (age > {32'd0, window_q});
  assign same      = (rdata_q.time_ms == pkt_time_q) && (rdata_q.hash == pkt_hash_q)
                  && (rdata_q.sender == pkt_sender_q);

  assign status_o.hit      = cur_valid && !expire && same;
  assign status_o.scan_end = (cmp_idx_q == LAST_IDX);

  assign wr_en             = cmd_i.finish && !cmd_i.dup;
  assign wr_entry.time_ms  = pkt_time_q;
  assign wr_entry.sender   = pkt_sender_q;
  assign wr_entry.hash     = pkt_hash_q;

  // entry ring storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_entry;
    end
    rdata_q <= mem[scan_idx_q];
  end

  // packet capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.launch) begin
      pkt_hash_q   <= hash_next;
      pkt_time_q   <= item_i.packet_timestamp;
      pkt_sender_q <= item_i.src_id;
    end
    if (cmd_i.finish) begin
      result_q.is_duplicate <= cmd_i.dup;
      result_q.digest       <= pkt_hash_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= WINDOW_RESET;
      run_hash_q     <= FNV_BASIS;
      valid_q        <= '0;
      ptr_q          <= '0;
      scan_idx_q     <= '0;
      cmp_idx_q      <= '0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        run_hash_q <= item_i.last_byte ? FNV_BASIS : hash_next;
      end
      cmp_idx_q <= scan_idx_q;
      if (cmd_i.launch) begin
        scan_idx_q <= '0;
      end else if (cmd_i.prime || cmd_i.scan) begin
        scan_idx_q <= scan_idx_next;
      end
      // expiry first, so an insert at the same slot wins
      if (cmd_i.scan && cur_valid && expire) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
      if (wr_en) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q          <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
      end
      result_valid_q <= cmd_i.finish;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// File: rtl/pdht_chk.sv
// port-level checker for the packet duplicate filter, bound to the top level
module pdht_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input pdht_pkg::item_t   item_i,
  input logic              result_valid_o
);
  import pdht_pkg::*;

  // a transfer without last_byte never raises busy
  a_byte_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !item_i.last_byte |=> !busy)
    else $error("busy after a non-last byte transfer");

  // a last byte transfer always starts a check
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.last_byte |=> busy && !result_valid_o)
    else $error("no check after last byte transfer");

  // a result is only shown as the check ends
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result outside the end of a check");

  // the result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind packet_dedup_hash_table pdht_chk u_pdht_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o)
);
